>>> hw/rtl/dtss_pkg.sv
package dtss_pkg;

  localparam int GRID_WIDTH  = 32;
  localparam int GRID_HEIGHT = 20;
  localparam int DIRTY_DEPTH = 32;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int DIRTY_AW   = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
  localparam int DCOUNT_W   = $clog2(DIRTY_DEPTH + 1);

  // queue depth must stay a power of two: pointers wrap by overflow
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_MARK   = 2'd1,
    REQ_RENDER = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef struct packed {
    logic [2:0] ink;
    logic [7:0] ch;
  } tile_t;

  typedef struct packed {
    logic [4:0] col;
    logic [4:0] row;
  } cell_t;

  typedef struct packed {
    req_t               op;
    cell_t              loc;
    tile_t              tile;
    logic [CELL_AW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic  full_redraw;
    cell_t loc;
    tile_t tile;
    logic  last;
  } res_t;

  function automatic logic [CELL_AW-1:0] cell_index(input cell_t c);
    int lin;
    lin = int'(c.row) * GRID_WIDTH + int'(c.col);
    return lin[CELL_AW-1:0];
  endfunction

  function automatic logic cell_ok(input cell_t c);
    return (int'(c.col) < GRID_WIDTH) && (int'(c.row) < GRID_HEIGHT);
  endfunction

endpackage

>>> hw/rtl/dirty_tile_screen_store.sv
// A write or mark updates the tile RAM and dirty list as it leaves the queue; a read result
// passes the RAM read register and then the output register; a list render steps through
// ST_LIST, ST_TILE and ST_EMIT for each listed cell. One write or mark per cycle while the
// back end is idle; during a read or render the next queued request waits: the tile RAM has
// one read port. Reset: dirty list empty, full redraw pending; the tile RAM is then swept
// to zero, all GRID_WIDTH*GRID_HEIGHT cells (640), with in_stall held high throughout.
module dirty_tile_screen_store import dtss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,

  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_tile_col,
  input  logic [4:0] in_tile_row,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_ink_color,

  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_full_redraw,
  output logic [4:0] out_col,
  output logic [4:0] out_row,
  output logic [7:0] out_char,
  output logic [2:0] out_ink,
  output logic       out_last_of_run
);

  cmd_t push_cmd, head;
  logic push, pop, q_empty, q_full, clear_done;
  res_t res;

  // front: range check, cell index, drop off-grid items
  dtss_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_tile_col  (in_tile_col),
    .in_tile_row  (in_tile_row),
    .in_char_code (in_char_code),
    .in_ink_color (in_ink_color),
    .q_full       (q_full),
    .clear_done   (clear_done),
    .push         (push),
    .cmd          (push_cmd)
  );

  // two-entry queue decouples intake from the RAM-bound back end
  dtss_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: tile RAM, dirty list, render sequencer and output register
  dtss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .clear_done (clear_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_full_redraw = res.full_redraw;
  assign out_col         = res.loc.col;
  assign out_row         = res.loc.row;
  assign out_char        = res.tile.ch;
  assign out_ink         = res.tile.ink;
  assign out_last_of_run = res.last;

endmodule

>>> hw/rtl/dtss_front.sv
module dtss_front import dtss_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_tile_col,
  input  logic [4:0] in_tile_row,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_ink_color,
  input  logic       q_full,
  input  logic       clear_done,
  output logic       push,
  output cmd_t       cmd
);

  logic  keep;
  cell_t loc;

  assign loc = '{col: in_tile_col, row: in_tile_row};

  // render always goes through; cell requests only when on the grid
  always_comb begin
    cmd.op   = req_t'(in_req_type);
    cmd.loc  = loc;
    cmd.tile = '{ink: in_ink_color, ch: in_char_code};
    cmd.idx  = cell_index(loc);
    keep     = (cmd.op == REQ_RENDER) || cell_ok(loc);
  end

  assign in_stall = !clear_done || q_full;
  assign push     = in_valid && !in_stall && keep;

endmodule

>>> hw/rtl/dtss_cmd_fifo.sv
module dtss_cmd_fifo import dtss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t                slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCOUNT_W-1:0] cnt_r;
  logic                do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (int'(cnt_r) == QUEUE_DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> hw/rtl/dtss_back.sv
module dtss_back import dtss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t head,
  input  logic q_empty,
  output logic pop,
  output logic clear_done,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDOUT,
    ST_FULL,
    ST_LIST,
    ST_TILE,
    ST_EMIT
  } state_t;

  tile_t              tile_mem [CELL_COUNT];
  cell_t              list_mem [DIRTY_DEPTH];

  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [DCOUNT_W-1:0] count_r, count_nxt;
  logic [DCOUNT_W-1:0] pos_r, pos_nxt;
  logic               redraw_r, redraw_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;
  cell_t              cur_r, cur_nxt;
  logic [CELL_AW-1:0] hold_addr_r;

  tile_t              rd_data_r;
  cell_t              list_q_r;

  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr, mem_raddr;
  tile_t              mem_wdata;
  logic               list_we;
  logic               out_free;
  logic               last;

  assign out_free   = !out_valid_r || !out_stall;
  assign clear_done = (state_r != ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign res        = res_r;
  assign last       = ((pos_r + 1'b1) == count_r);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    redraw_nxt    = redraw_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    cur_nxt       = cur_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = head.idx;
    mem_wdata     = head.tile;
    mem_raddr     = hold_addr_r;
    list_we       = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (int'(clr_addr_r) == CELL_COUNT - 1) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        mem_raddr = head.idx;
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.op) inside
            REQ_WRITE, REQ_MARK: begin
              if (head.op == REQ_WRITE) mem_we = 1'b1;
              if ((int'(count_r) < DIRTY_DEPTH) && !redraw_r) begin
                list_we   = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                count_nxt  = '0;
                redraw_nxt = 1'b1;
              end
            end
            REQ_READ: begin
              cur_nxt   = head.loc;
              state_nxt = ST_RDOUT;
            end
            REQ_RENDER: begin
              pos_nxt = '0;
              if (redraw_r)              state_nxt = ST_FULL;
              else if (count_r != '0)    state_nxt = ST_LIST;
            end
            default: ;
          endcase
        end
      end

      ST_RDOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt = '{full_redraw: 1'b0, loc: cur_r, tile: rd_data_r, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end

      ST_FULL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt = '{full_redraw: 1'b1, loc: '0, tile: '0, last: 1'b1};
          redraw_nxt = 1'b0;
          count_nxt  = '0;
          state_nxt  = ST_IDLE;
        end
      end

      // list read of entry pos_r lands at the end of this cycle
      ST_LIST: state_nxt = ST_TILE;

      ST_TILE: begin
        mem_raddr = cell_index(list_q_r);
        cur_nxt   = list_q_r;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt = '{full_redraw: 1'b0, loc: cur_r, tile: rd_data_r, last: last};
          pos_nxt = pos_r + 1'b1;
          if (last) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LIST;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) tile_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= tile_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[count_r[DIRTY_AW-1:0]] <= head.loc;
    list_q_r <= list_mem[pos_r[DIRTY_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      redraw_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      redraw_r    <= redraw_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r       <= res_nxt;
    cur_r       <= cur_nxt;
    hold_addr_r <= mem_raddr;
  end

endmodule

>>> tb/sv/dirty_tile_screen_store_tb.sv
module dirty_tile_screen_store_tb import dtss_pkg::*; ();

  // Shadow copy of the screen store: tile contents, dirty list and redraw flag.
  // Each accepted request updates it and queues the changes the block must emit.
  class screen_shadow;
    tile_t cells [CELL_COUNT];
    cell_t dirty_list [DIRTY_DEPTH];
    int    dirty_fill;
    bit    redraw_pending;
    res_t  awaited [$];
    int    faults;

    function new();
      foreach (cells[i]) cells[i] = '0;
      dirty_fill     = 0;
      redraw_pending = 1'b1;
      faults         = 0;
    endfunction

    function void note_fault(string what);
      faults++;
      if (faults <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void mark_cell(cell_t c);
      if (dirty_fill < DIRTY_DEPTH && !redraw_pending) begin
        dirty_list[dirty_fill] = c;
        dirty_fill++;
      end else begin
        dirty_fill     = 0;
        redraw_pending = 1'b1;
      end
    endfunction

    function void apply_request(req_t op, cell_t c, tile_t t);
      res_t r;
      bit   on_grid;
      int   slot;
      int   i;
      on_grid = (int'(c.col) < GRID_WIDTH) && (int'(c.row) < GRID_HEIGHT);
      slot    = int'(c.row) * GRID_WIDTH + int'(c.col);
      case (op)
        REQ_WRITE: begin
          if (on_grid) begin
            cells[slot] = t;
            mark_cell(c);
          end
        end
        REQ_MARK: begin
          if (on_grid) mark_cell(c);
        end
        REQ_RENDER: begin
          if (redraw_pending) begin
            r             = '0;
            r.full_redraw = 1'b1;
            r.last        = 1'b1;
            awaited.push_back(r);
            redraw_pending = 1'b0;
          end else begin
            for (i = 0; i < dirty_fill; i++) begin
              r.full_redraw = 1'b0;
              r.loc         = dirty_list[i];
              r.tile        = cells[int'(dirty_list[i].row) * GRID_WIDTH
                                    + int'(dirty_list[i].col)];
              r.last        = (i == dirty_fill - 1);
              awaited.push_back(r);
            end
          end
          dirty_fill = 0;
        end
        REQ_READ: begin
          if (on_grid) begin
            r.full_redraw = 1'b0;
            r.loc         = c;
            r.tile        = cells[slot];
            r.last        = 1'b1;
            awaited.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void match_change(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        note_fault($sformatf({"result with none pending: ",
                              "full=%0b col=%0d row=%0d ch=%02h ink=%0d last=%0b"},
                             got.full_redraw, got.loc.col, got.loc.row, got.tile.ch,
                             got.tile.ink, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.full_redraw !== want.full_redraw || got.loc.col !== want.loc.col ||
          got.loc.row !== want.loc.row || got.tile.ch !== want.tile.ch ||
          got.tile.ink !== want.tile.ink || got.last !== want.last)
        note_fault($sformatf({"mismatch: exp full=%0b col=%0d row=%0d ch=%02h ink=%0d last=%0b",
                              " / got full=%0b col=%0d row=%0d ch=%02h ink=%0d last=%0b"},
                             want.full_redraw, want.loc.col, want.loc.row, want.tile.ch,
                             want.tile.ink, want.last,
                             got.full_redraw, got.loc.col, got.loc.row, got.tile.ch,
                             got.tile.ink, got.last));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_req_type;
  logic [4:0] in_tile_col;
  logic [4:0] in_tile_row;
  logic [7:0] in_char_code;
  logic [2:0] in_ink_color;
  logic       out_valid;
  logic       out_stall;
  logic       out_full_redraw;
  logic [4:0] out_col;
  logic [4:0] out_row;
  logic [7:0] out_char;
  logic [2:0] out_ink;
  logic       out_last_of_run;

  screen_shadow shadow;
  bit           quiet;     // set for the closing stretch: no gaps, no stalls
  int           counted;   // items that do something (ignored ones left out)

  dirty_tile_screen_store u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_tile_col     (in_tile_col),
    .in_tile_row     (in_tile_row),
    .in_char_code    (in_char_code),
    .in_ink_color    (in_ink_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_full_redraw (out_full_redraw),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_char        (out_char),
    .out_ink         (out_ink),
    .out_last_of_run (out_last_of_run)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Both handshakes are sampled on the rising edge; all driving happens on the
  // falling edge, so nothing here races the block's own registers.
  // Results are checked before the request of the same edge is applied; a
  // result can never belong to a request taken on that very edge.
  always @(posedge clk) begin
    res_t  got;
    cell_t c;
    tile_t t;
    if (rst_n && out_valid && !out_stall) begin
      got.full_redraw = out_full_redraw;
      got.loc.col     = out_col;
      got.loc.row     = out_row;
      got.tile.ch     = out_char;
      got.tile.ink    = out_ink;
      got.last        = out_last_of_run;
      shadow.match_change(got);
    end
    if (rst_n && in_valid && !in_stall) begin
      c.col  = in_tile_col;
      c.row  = in_tile_row;
      t.ch   = in_char_code;
      t.ink  = in_ink_color;
      shadow.apply_request(req_t'(in_req_type), c, t);
    end
  end

  // Result-side back-pressure: random stall and free stretches of random length, none
  // once the closing stretch begins.
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (quiet) begin
        out_stall = 1'b0;
        @(negedge clk);
      end else begin
        out_stall = ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Offer one item and hold it until taken. An optional gap with valid low
  // goes first. Returns just after the accepting edge.
  task automatic send_request(input req_t op, input logic [4:0] col, input logic [4:0] row,
                              input logic [7:0] ch, input logic [2:0] ink);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_req_type  = op;
    in_tile_col  = col;
    in_tile_row  = row;
    in_char_code = ch;
    in_ink_color = ink;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == REQ_RENDER || (int'(col) < GRID_WIDTH && int'(row) < GRID_HEIGHT))
      counted++;
    if (counted >= 175) quiet = 1'b1;
  endtask

  // Write or mark a random on-grid cell with random contents.
  task automatic touch_cell();
    req_t op;
    op = ($urandom_range(0, 2) == 0) ? REQ_MARK : REQ_WRITE;
    send_request(op, 5'($urandom_range(0, GRID_WIDTH - 1)),
                 5'($urandom_range(0, GRID_HEIGHT - 1)),
                 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    int pick;
    shadow       = new();
    quiet        = 1'b0;
    counted      = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_WRITE;
    in_tile_col  = '0;
    in_tile_row  = '0;
    in_char_code = '0;
    in_ink_color = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // the block then sweeps its tile RAM with in_stall high; the handshake covers it

    // --- directed part ---
    // marking while the post-reset redraw is pending keeps the redraw flag
    send_request(REQ_MARK, 5'd2, 5'd2, 8'h00, 3'd0);
    send_request(REQ_RENDER, 5'd0, 5'd0, 8'h00, 3'd0);   // full redraw
    send_request(REQ_RENDER, 5'd31, 5'd31, 8'hFF, 3'd7); // empty list: nothing
    send_request(REQ_READ, 5'd0, 5'd0, 8'h00, 3'd0);     // cleared at reset
    send_request(REQ_WRITE, 5'd31, 5'd19, 8'hFF, 3'd7);  // far corner
    send_request(REQ_WRITE, 5'd0, 5'd0, 8'h00, 3'd0);
    send_request(REQ_WRITE, 5'd5, 5'd3, 8'hA5, 3'd5);
    send_request(REQ_MARK, 5'd31, 5'd19, 8'h5A, 3'd2);   // duplicate, kept twice
    // rows past the grid do nothing at all
    send_request(REQ_WRITE, 5'd3, 5'd20, 8'h77, 3'd3);
    send_request(REQ_MARK, 5'd3, 5'd31, 8'h00, 3'd0);
    send_request(REQ_READ, 5'd3, 5'd25, 8'h00, 3'd0);
    send_request(REQ_RENDER, 5'd0, 5'd0, 8'h00, 3'd0);   // four listed cells
    send_request(REQ_READ, 5'd31, 5'd19, 8'h00, 3'd0);
    send_request(REQ_READ, 5'd5, 5'd3, 8'h00, 3'd0);
    send_request(REQ_WRITE, 5'd5, 5'd3, 8'h12, 3'd1);    // overwrite then render
    send_request(REQ_RENDER, 5'd0, 5'd0, 8'h00, 3'd0);
    send_request(REQ_RENDER, 5'd0, 5'd0, 8'h00, 3'd0);   // list now empty

    // --- random part ---
    // Mostly frames: some tile updates and reads closed by a render. Some
    // frames run the list to its end and past it, to reach the overflow
    // redraw and the longest runs. The rest is unstructured noise.
    while (counted < 210) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 4) == 0)
            send_request(REQ_READ, 5'($urandom_range(0, GRID_WIDTH - 1)),
                         5'($urandom_range(0, GRID_HEIGHT - 1)),
                         8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
          else
            touch_cell();
        end
        send_request(REQ_RENDER, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end else if (pick < 70) begin
        repeat ($urandom_range(DIRTY_DEPTH - 2, DIRTY_DEPTH + 3)) touch_cell();
        send_request(REQ_RENDER, 5'd0, 5'd0, 8'h00, 3'd0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4))
          send_request(req_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                       3'($urandom_range(0, 7)));
      end else begin
        repeat ($urandom_range(1, 3))
          send_request(REQ_READ, 5'($urandom_range(0, GRID_WIDTH - 1)),
                       5'($urandom_range(0, GRID_HEIGHT - 1)), 8'h00, 3'd0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;

    // drain, then watch a while longer for anything stray
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (shadow.awaited.size() != 0)
      shadow.note_fault($sformatf("%0d expected results never arrived", shadow.awaited.size()));

    if (shadow.faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run (reset sweep plus every render
  // at full length under maximum stall).
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
